// ===== rtl/wrlm_pkg.sv =====
// Shared types, constants and the microcode program of the windowed RMS level meter.
// Used by every module of the block; depends on nothing else.
package wrlm_pkg;

  localparam int MAX_WINDOW = 4096;
  localparam int SAMPLE_W   = 16;
  localparam int PROD_W     = 2 * SAMPLE_W - 1;
  localparam int TALLY_W    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = PROD_W + TALLY_W - 1;
  localparam int GAIN_W     = 6;
  localparam int LEVEL_W    = 16;
  localparam int SCALED_W   = LEVEL_W + GAIN_W;
  localparam int RAD_W      = 2 * LEVEL_W;
  localparam int ROOT_W     = LEVEL_W;
  localparam int SREM_W     = ROOT_W + 1;
  localparam int CNT_W      = $clog2(SUM_W + 1);
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W     = 4;

  localparam logic [LEVEL_W-1:0]    LEVEL_ONE     = 16'h8000;
  localparam logic [GAIN_W-1:0]     GAIN_RESET    = 6'd10;
  localparam logic [LEVEL_W-1:0]    FLOOR_RESET   = 16'd3277;
  localparam logic [CNT_W-1:0]      DIV_STEPS     = CNT_W'(SUM_W);
  localparam logic [CNT_W-1:0]      ROOT_STEPS    = CNT_W'(ROOT_W);

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_FLOOR = 1'b1;

  // Step addresses used as jump targets.
  localparam logic [STEP_W-1:0] STEP_TAKE = 4'd0;
  localparam logic [STEP_W-1:0] STEP_DIV  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_ROOT = 4'd6;
  localparam logic [STEP_W-1:0] STEP_WAIT = 4'd8;

  typedef enum logic [3:0] {
    OP_TAKE,
    OP_SQUARE,
    OP_ACCUM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_ROOT_INIT,
    OP_ROOT_STEP,
    OP_SCALE,
    OP_WAIT,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_INPUT,
    C_NOT_LAST,
    C_LOOP,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
    logic              load_cnt;
    logic [CNT_W-1:0]  count;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic last;
    logic out_busy;
  } seq_status_t;

  function automatic ctrl_word_t cw(op_t op, cond_t cond, logic [STEP_W-1:0] target,
                                    logic load_cnt, logic [CNT_W-1:0] count);
    ctrl_word_t w;
    w.op       = op;
    w.cond     = cond;
    w.target   = target;
    w.load_cnt = load_cnt;
    w.count    = count;
    return w;
  endfunction

  // The program: one control word per step.
  function automatic ctrl_word_t microcode(logic [STEP_W-1:0] step);
    ctrl_word_t w;
    case (step)
      4'd0:    w = cw(OP_TAKE,      C_NO_INPUT, STEP_TAKE, 1'b0, '0);
      4'd1:    w = cw(OP_SQUARE,    C_NEXT,     STEP_TAKE, 1'b0, '0);
      4'd2:    w = cw(OP_ACCUM,     C_NOT_LAST, STEP_TAKE, 1'b0, '0);
      4'd3:    w = cw(OP_DIV_INIT,  C_NEXT,     STEP_TAKE, 1'b1, DIV_STEPS);
      4'd4:    w = cw(OP_DIV_STEP,  C_LOOP,     STEP_DIV,  1'b0, '0);
      4'd5:    w = cw(OP_ROOT_INIT, C_NEXT,     STEP_TAKE, 1'b1, ROOT_STEPS);
      4'd6:    w = cw(OP_ROOT_STEP, C_LOOP,     STEP_ROOT, 1'b0, '0);
      4'd7:    w = cw(OP_SCALE,     C_NEXT,     STEP_TAKE, 1'b0, '0);
      4'd8:    w = cw(OP_WAIT,      C_OUT_BUSY, STEP_WAIT, 1'b0, '0);
      4'd9:    w = cw(OP_EMIT,      C_ALWAYS,   STEP_TAKE, 1'b0, '0);
      default: w = cw(OP_WAIT,      C_ALWAYS,   STEP_TAKE, 1'b0, '0);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/windowed_rms_level_meter.sv =====
// Top level of the windowed RMS level meter: sequencer plus datapath.
// Depends on wrlm_pkg, wrlm_seq and wrlm_dp.
//
// The meter takes signed 16-bit PCM samples, one word at a time, and sums
// their squares over a window that ends with the word marked by s_tlast. At
// the end of the window it emits one level in Q1.15 (32768 means 1.0):
// floor(sqrt(floor(sum / count))) times level_gain, clamped to at most 1.0
// and at least level_floor (a floor above 1.0 acts as 1.0). The sum, the
// count and the overflow flag are then cleared. A window longer than 4096
// samples keeps only its first 4096 samples and reports m_tuser = 1.
// A sample that does not end a window passes through the take, square and
// accumulate steps before the next one is accepted. A sample that ends a
// window then runs the restoring divider (one quotient bit per cycle over
// the 43-bit sum), the square root (one root bit per cycle), the gain
// multiply and the hand-over of the result. All steps come from a
// ten-word microcode program; a pending result that the sink has not taken
// holds the program before the next result is written, while earlier
// samples of the next window can still be accepted up to that point.
// Configuration: cfg_addr 0 is level_gain (bits 5:0), 1 is level_floor.
module windowed_rms_level_meter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [wrlm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [wrlm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [wrlm_pkg::SAMPLE_W-1:0]   s_tdata,   // [15:0] sample
  input  logic                            s_tlast,   // last_sample
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [wrlm_pkg::LEVEL_W-1:0]    m_tdata,   // [15:0] level
  output logic                            m_tuser    // [0] window_overflow
);
  import wrlm_pkg::*;

  ctrl_word_t  ctrl;
  seq_status_t status;

  // The sequencer owns the step and loop counters; the datapath only decodes
  // the operation of the current step and reports back what the jumps need.
  wrlm_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  wrlm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ===== rtl/wrlm_seq.sv =====
// Microcode sequencer: step counter, loop counter and jump logic over the program ROM.
// Depends on wrlm_pkg for the control word layout and the program itself.
module wrlm_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  wrlm_pkg::seq_status_t status,
  output wrlm_pkg::ctrl_word_t  ctrl
);
  import wrlm_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic              jump;

  assign ctrl = microcode(step);

  always_comb begin
    case (ctrl.cond)
      C_NEXT:     jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_INPUT: jump = !status.in_valid;
      C_NOT_LAST: jump = !status.last;
      C_LOOP:     jump = (cnt != CNT_W'(1));
      C_OUT_BUSY: jump = status.out_busy;
      default:    jump = 1'b1;
    endcase
    step_next = jump ? ctrl.target : step + STEP_W'(1);
    if (ctrl.load_cnt) begin
      cnt_next = ctrl.count;
    end else if (ctrl.cond == C_LOOP) begin
      cnt_next = cnt - CNT_W'(1);
    end else begin
      cnt_next = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_TAKE;
      cnt  <= '0;
    end else begin
      step <= step_next;
      cnt  <= cnt_next;
    end
  end

endmodule

// ===== rtl/wrlm_dp.sv =====
// Datapath: accumulator, restoring divider, digit-by-digit square root, gain and clamp.
// Driven by control words from wrlm_seq; depends on wrlm_pkg.
module wrlm_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  wrlm_pkg::ctrl_word_t              ctrl,
  output wrlm_pkg::seq_status_t             status,
  input  logic                              cfg_we,
  input  logic [wrlm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [wrlm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [wrlm_pkg::SAMPLE_W-1:0]     s_tdata,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [wrlm_pkg::LEVEL_W-1:0]      m_tdata,
  output logic                              m_tuser
);
  import wrlm_pkg::*;

  logic [GAIN_W-1:0]          gain;
  logic [LEVEL_W-1:0]         floor_cfg;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       last_q;
  logic [PROD_W-1:0]          prod;
  logic [SUM_W-1:0]           square_sum;
  logic [TALLY_W-1:0]         sample_tally;
  logic                       overflow_seen;
  logic [SUM_W-1:0]           quo;
  logic [TALLY_W-1:0]         drem;
  logic [RAD_W-1:0]           rad;
  logic [ROOT_W-1:0]          root;
  logic [SREM_W-1:0]          srem;
  logic [SCALED_W-1:0]        scaled;

  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic [TALLY_W:0]             div_shift;
  logic [TALLY_W:0]             div_diff;
  logic                         div_bit;
  logic [SREM_W+1:0]            root_shift;
  logic [SREM_W+1:0]            root_trial;
  logic [SREM_W+1:0]            root_diff;
  logic                         root_bit;
  logic [LEVEL_W-1:0]           floor_eff;
  logic [LEVEL_W-1:0]           level_next;
  logic                         take;

  assign s_tready = (ctrl.op == OP_TAKE);
  assign take     = s_tvalid && s_tready;

  assign status.in_valid = s_tvalid;
  assign status.last     = last_q;
  assign status.out_busy = m_tvalid && !m_tready;

  assign sq_full = sample_q * sample_q;

  // One quotient bit per step; the remainder never exceeds the window count.
  assign div_shift = {drem, quo[SUM_W-1]};
  assign div_diff  = div_shift - {1'b0, sample_tally};
  assign div_bit   = (div_shift >= {1'b0, sample_tally});

  // One root bit per step from two radicand bits.
  assign root_shift = {srem, rad[RAD_W-1 -: 2]};
  assign root_trial = {1'b0, root, 2'b01};
  assign root_diff  = root_shift - root_trial;
  assign root_bit   = (root_shift >= root_trial);

  always_comb begin
    floor_eff = (floor_cfg > LEVEL_ONE) ? LEVEL_ONE : floor_cfg;
    if (scaled > SCALED_W'(LEVEL_ONE)) begin
      level_next = LEVEL_ONE;
    end else if (scaled < SCALED_W'(floor_eff)) begin
      level_next = floor_eff;
    end else begin
      level_next = scaled[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= GAIN_RESET;
      floor_cfg <= FLOOR_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GAIN:  gain      <= cfg_wdata[GAIN_W-1:0];
        REG_FLOOR: floor_cfg <= cfg_wdata[LEVEL_W-1:0];
        default:   gain      <= gain;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum    <= '0;
      sample_tally  <= '0;
      overflow_seen <= 1'b0;
      last_q        <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (ctrl.op)
        OP_TAKE: begin
          if (take) begin
            sample_q <= s_tdata;
            last_q   <= s_tlast;
          end
        end
        OP_SQUARE: prod <= sq_full[PROD_W-1:0];
        OP_ACCUM: begin
          if (sample_tally >= TALLY_W'(MAX_WINDOW)) begin
            overflow_seen <= 1'b1;
          end else begin
            square_sum   <= square_sum + SUM_W'(prod);
            sample_tally <= sample_tally + TALLY_W'(1);
          end
        end
        OP_DIV_INIT: begin
          quo  <= square_sum;
          drem <= '0;
        end
        OP_DIV_STEP: begin
          quo  <= {quo[SUM_W-2:0], div_bit};
          drem <= div_bit ? div_diff[TALLY_W-1:0] : div_shift[TALLY_W-1:0];
        end
        OP_ROOT_INIT: begin
          // A zero count gives a zero mean.
          rad  <= (sample_tally == '0) ? '0 : quo[RAD_W-1:0];
          root <= '0;
          srem <= '0;
        end
        OP_ROOT_STEP: begin
          rad  <= {rad[RAD_W-3:0], 2'b00};
          root <= {root[ROOT_W-2:0], root_bit};
          srem <= root_bit ? root_diff[SREM_W-1:0] : root_shift[SREM_W-1:0];
        end
        OP_SCALE: scaled <= SCALED_W'(root) * SCALED_W'(gain);
        OP_EMIT: begin
          m_tdata       <= level_next;
          m_tuser       <= overflow_seen;
          m_tvalid      <= 1'b1;
          square_sum    <= '0;
          sample_tally  <= '0;
          overflow_seen <= 1'b0;
        end
        default: last_q <= last_q;
      endcase
    end
  end

endmodule

// ===== rtl/wrlm_checker.sv =====
// Port-level checks for the windowed RMS level meter, bound to the top level.
// Depends on wrlm_pkg and windowed_rms_level_meter.
module wrlm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            s_tlast,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [wrlm_pkg::LEVEL_W-1:0]    m_tdata,
  input logic                            m_tuser
);
  import wrlm_pkg::*;

  // A result that waits holds its word.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // The level never exceeds 1.0.
  a_level_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata <= LEVEL_ONE))
    else $error("level above 1.0");

  // Mid-window, input stays blocked through the square and accumulate steps.
  a_mid_rate: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast |=> !s_tready ##1 !s_tready ##1 s_tready)
    else $error("non-final sample timing wrong");

  // A new result only appears while the input side is busy computing it.
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared while idle");

endmodule

bind windowed_rms_level_meter wrlm_checker u_wrlm_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .s_tlast   (s_tlast),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser)
);

// ===== sim/tb.sv =====
// Self-checking testbench for the windowed RMS level meter.
// Depends on wrlm_pkg and windowed_rms_level_meter; drives random windows of PCM words
// and checks every emitted level against a cycle-free predictor of the meter.
module tb;
  import wrlm_pkg::*;

  localparam int  BLOCK_LATENCY = 70;
  localparam int  TAIL_CYCLES   = BLOCK_LATENCY + 30;
  localparam longint CYCLE_LIMIT = 6_000_000;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } pcm_word_t;

  typedef struct {
    logic [LEVEL_W-1:0] level;
    logic               overflow;
  } meter_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata = '0;   // [15:0] sample
  logic                  s_tlast = 1'b0; // last_sample
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [LEVEL_W-1:0]    m_tdata;        // [15:0] level
  logic                  m_tuser;        // [0] window_overflow

  windowed_rms_level_meter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Words waiting to be sent and levels waiting to be received.
  pcm_word_t     sample_q[$];
  meter_result_t level_q[$];

  // Predictor state: running window plus a shadow of the two registers.
  logic [SUM_W-1:0]   win_sum   = '0;
  logic [TALLY_W-1:0] win_count = '0;
  logic               win_over  = 1'b0;
  logic [GAIN_W-1:0]  shadow_gain  = GAIN_RESET;
  logic [LEVEL_W-1:0] shadow_floor = FLOOR_RESET;

  int     errors = 0;
  longint cycles = 0;
  longint words_sent = 0;
  longint words_taken = 0;
  int     send_gap = 0;
  int     stall_left = 0;
  bit     in_steady = 1'b0;
  bit     out_steady = 1'b0;

  task automatic report(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    errors++;
  endtask

  // Mostly short idle runs, now and then a long one; none in a steady stretch.
  function automatic int gap_len(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Floor of the square root, found one root bit at a time from the top.
  function automatic logic [ROOT_W:0] int_sqrt(input logic [SUM_W-1:0] v);
    logic [ROOT_W:0] r;
    logic [ROOT_W:0] t;
    r = '0;
    for (int b = ROOT_W; b >= 0; b--) begin
      t = r | ((ROOT_W + 1)'(1) << b);
      if (longint'(t) * longint'(t) <= longint'(v)) r = t;
    end
    return r;
  endfunction

  // Folds one accepted word into the window; a word marked last closes the window
  // and queues the level it must produce.
  task automatic absorb_sample(input logic [SAMPLE_W-1:0] raw, input logic last);
    logic signed [SAMPLE_W-1:0] s;
    logic [SUM_W-1:0]           mean;
    logic [ROOT_W:0]            root;
    logic [ROOT_W+GAIN_W:0]     scaled;
    logic [LEVEL_W-1:0]         eff_floor;
    meter_result_t              res;
    s = raw;
    if (win_count >= TALLY_W'(MAX_WINDOW)) begin
      win_over = 1'b1;
    end else begin
      win_sum   = win_sum + SUM_W'(longint'(s) * longint'(s));
      win_count = win_count + 1'b1;
    end
    if (last) begin
      mean      = (win_count != 0) ? win_sum / win_count : '0;
      root      = int_sqrt(mean);
      scaled    = root * shadow_gain;
      eff_floor = (shadow_floor > LEVEL_ONE) ? LEVEL_ONE : shadow_floor;
      // The clamp at 1.0 is tested before the floor.
      if (scaled > LEVEL_ONE) res.level = LEVEL_ONE;
      else if (scaled < eff_floor) res.level = eff_floor;
      else res.level = scaled[LEVEL_W-1:0];
      res.overflow = win_over;
      level_q.insert(level_q.size(), res);
      win_sum   = '0;
      win_count = '0;
      win_over  = 1'b0;
    end
  endtask

  // Driver: a new word goes out only once the previous one has been taken.
  always @(negedge clk) begin
    pcm_word_t w;
    if ($urandom_range(0, 299) == 0) in_steady = !in_steady;
    if (!s_tvalid || words_taken == words_sent) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        w = sample_q.pop_front();
        s_tdata  <= w.sample;
        s_tlast  <= w.last;
        s_tvalid <= 1'b1;
        words_sent++;
        send_gap = gap_len(in_steady);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Sink: back-pressure with random stall runs.
  always @(negedge clk) begin
    int n;
    if ($urandom_range(0, 299) == 0) out_steady = !out_steady;
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      n = gap_len(out_steady);
      if (n > 0) begin
        stall_left = n - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on every accepted input word, checks every accepted level.
  always @(posedge clk) begin
    meter_result_t exp_res;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("windowed_rms_level_meter regression: fail");
      $finish;
    end else if (!rst) begin
      if (s_tvalid && s_tready) begin
        words_taken++;
        absorb_sample(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        if (level_q.size() == 0) begin
          report($sformatf("level %0d with no window closed", m_tdata));
        end else begin
          exp_res = level_q.pop_front();
          if (m_tdata !== exp_res.level)
            report($sformatf("level %0d, expected %0d", m_tdata, exp_res.level));
          if (m_tuser !== exp_res.overflow)
            report($sformatf("overflow flag %b, expected %b", m_tuser, exp_res.overflow));
        end
      end
    end
  end

  task automatic push_word(input logic [SAMPLE_W-1:0] sample, input logic last);
    pcm_word_t w;
    w.sample = sample;
    w.last   = last;
    sample_q.insert(sample_q.size(), w);
  endtask

  // Mostly uniform in [-amp, amp), with an occasional full-scale, zero or minus-one word.
  function automatic logic [SAMPLE_W-1:0] pick_sample(input int amp);
    int v;
    if ($urandom_range(0, 39) == 0) begin
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    v = int'($urandom_range(0, 2 * amp - 1)) - amp;
    return v[SAMPLE_W-1:0];
  endfunction

  // Words past the saturation point are drawn over the full sample range, so wrongly counting them shows.
  task automatic queue_window(input int len, input int amp);
    for (int i = 0; i < len; i++)
      push_word(pick_sample(i < MAX_WINDOW ? amp : 32768), i == len - 1);
  endtask

  // Windows of random length, each with its own amplitude so levels span
  // the floor, the linear range and the clamp at 1.0.
  task automatic queue_random(input int n_words);
    int queued;
    int len;
    int amp;
    queued = 0;
    while (queued < n_words) begin
      case ($urandom_range(0, 9))
        0:       len = 1;
        1, 2, 3, 4, 5, 6: len = $urandom_range(2, 16);
        7, 8:    len = $urandom_range(17, 64);
        default: len = $urandom_range(65, 200);
      endcase
      amp = ($urandom_range(0, 7) == 0) ? 32768 : (1 << $urandom_range(0, 15));
      queue_window(len, amp);
      queued += len;
    end
  endtask

  // Waits until every word is sent and every level received, then lets the
  // block settle before the registers may change.
  task automatic drain();
    while (sample_q.size() != 0 || s_tvalid || level_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_GAIN) shadow_gain = data[GAIN_W-1:0];
    else shadow_floor = data;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: clamp at 1.0, both sides of the floor, both sides of
    // the upper clamp, and a window of two words.
    push_word(16'h8000, 1'b1);
    push_word(16'h7FFF, 1'b1);
    push_word(16'h0000, 1'b1);
    push_word(16'd327, 1'b1);
    push_word(16'd328, 1'b1);
    push_word(16'd3276, 1'b1);
    push_word(16'd3277, 1'b1);
    push_word(16'h0001, 1'b0);
    push_word(16'hFFFF, 1'b1);
    queue_random(300);
    drain();

    // Unit gain, no floor: the level follows the root directly.
    write_reg(REG_GAIN, 16'd1);
    write_reg(REG_FLOOR, 16'd0);
    push_word(16'h0000, 1'b1);
    push_word(16'h8000, 1'b1);
    push_word(16'h7FFF, 1'b1);
    queue_random(250);
    drain();

    // Largest gain with the floor at exactly 1.0.
    write_reg(REG_GAIN, 16'd63);
    write_reg(REG_FLOOR, 16'h8000);
    push_word(16'h0000, 1'b1);
    queue_random(150);
    drain();

    // Gain 8 makes a root of 4096 land exactly on 1.0.
    write_reg(REG_GAIN, 16'd8);
    write_reg(REG_FLOOR, 16'd0);
    push_word(16'd4096, 1'b1);
    push_word(16'd4097, 1'b1);
    queue_random(150);
    drain();

    // Zero gain with a floor above 1.0: the floor acts as 1.0.
    write_reg(REG_GAIN, 16'd0);
    write_reg(REG_FLOOR, 16'hFFFF);
    push_word(16'h7FFF, 1'b1);
    queue_random(100);
    drain();

    // Back to the reset settings.
    write_reg(REG_GAIN, 16'd10);
    write_reg(REG_FLOOR, 16'd3277);
    queue_random(100);
    drain();

    // Random settings; the gain write carries random upper bits too.
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_GAIN, 16'($urandom_range(0, 65535)));
      write_reg(REG_FLOOR, ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 6000))
                                                     : 16'($urandom_range(0, 65535)));
      queue_random(120);
      drain();
    end

    if (errors == 0) begin
      $display("windowed_rms_level_meter regression: pass");
    end else begin
      $display("windowed_rms_level_meter regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wrlm_pkg.sv
rtl/wrlm_seq.sv
rtl/wrlm_dp.sv
rtl/windowed_rms_level_meter.sv
rtl/wrlm_checker.sv
sim/tb.sv
